FILE: rtl/upd_pkg.sv
// Package for the URL percent decoder: character codes, queue sizing and
// the result bundle that travels from the front end to the back end.
// No dependencies.
package upd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ALL_ONES  = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_DIGIT   = 2'd2,
        PH_UNUSED  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic            term;
        logic [2:0][7:0] data;
    } t_bundle;

endpackage

FILE: rtl/upd_front.sv
// Front end of the URL percent decoder: accepts input bytes, tracks the
// escape phase and turns each byte into a bundle of up to three results.
// Depends on upd_pkg.
module upd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_allow_cr,
    input  logic             i_valid,
    input  logic [7:0]       i_char_byte,
    input  logic             i_queue_full,
    output logic             o_ready,
    output logic             o_push,
    output upd_pkg::t_bundle o_bundle
);
    import upd_pkg::*;

    logic       r_allow_cr;
    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_halted, n_halted;

    logic            accept;
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            term;
    logic            has_any;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic       do_plain;
        logic [7:0] u;
        cnt      = 2'd0;
        data     = '0;
        term     = 1'b0;
        has_any  = 1'b0;
        do_plain = 1'b0;
        u        = {hex_val(r_held), hex_val(i_char_byte)};
        n_phase  = r_phase;
        n_held   = r_held;
        n_halted = r_halted;

        if (i_char_byte == CH_NUL) begin
            if (!r_halted) begin
                if (r_phase == PH_PERCENT) begin
                    data[cnt] = CH_PERCENT;
                    cnt       = cnt + 2'd1;
                end else if (r_phase == PH_DIGIT) begin
                    data[cnt] = CH_PERCENT;
                    cnt       = cnt + 2'd1;
                    data[cnt] = r_held;
                    cnt       = cnt + 2'd1;
                end
            end
            data[cnt] = CH_NUL;
            term      = 1'b1;
            has_any   = 1'b1;
            n_phase   = PH_IDLE;
            n_held    = '0;
            n_halted  = 1'b0;
        end else if (r_halted) begin
            has_any = 1'b0;
        end else if (r_phase == PH_PERCENT) begin
            if (is_hex(i_char_byte)) begin
                n_held  = i_char_byte;
                n_phase = PH_DIGIT;
            end else begin
                n_phase   = PH_IDLE;
                data[cnt] = CH_PERCENT;
                cnt       = cnt + 2'd1;
                do_plain  = 1'b1;
            end
        end else if (r_phase == PH_DIGIT) begin
            n_phase = PH_IDLE;
            if (is_hex(i_char_byte)) begin
                if (r_allow_cr && u != CH_CR) begin
                    data[cnt] = u;
                    cnt       = cnt + 2'd1;
                end else if (!r_allow_cr && u != CH_CR && u != CH_LF) begin
                    if (u == CH_QUOTE || u == CH_BACKSLASH) begin
                        data[cnt] = CH_BACKSLASH;
                        cnt       = cnt + 2'd1;
                    end else if (u == CH_ALL_ONES) begin
                        data[cnt] = CH_ALL_ONES;
                        cnt       = cnt + 2'd1;
                    end
                    data[cnt] = u;
                    cnt       = cnt + 2'd1;
                end
            end else begin
                data[cnt] = CH_PERCENT;
                cnt       = cnt + 2'd1;
                data[cnt] = r_held;
                cnt       = cnt + 2'd1;
                do_plain  = 1'b1;
            end
        end else begin
            n_phase  = PH_IDLE;
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (i_char_byte == CH_PERCENT) begin
                n_phase = PH_PERCENT;
            end else if (!r_allow_cr && i_char_byte == CH_QUESTION) begin
                n_halted = 1'b1;
            end else if (i_char_byte == CH_PLUS) begin
                data[cnt] = CH_SPACE;
                cnt       = cnt + 2'd1;
            end else begin
                data[cnt] = i_char_byte;
                cnt       = cnt + 2'd1;
            end
        end

        if (cnt != 2'd0 && !term) begin
            has_any = 1'b1;
        end
    end

    assign o_push            = accept && has_any;
    assign o_bundle.data     = data;
    assign o_bundle.term     = term;
    assign o_bundle.last_idx = term ? cnt : cnt - 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_cr <= 1'b0;
            r_phase    <= PH_IDLE;
            r_held     <= '0;
            r_halted   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_allow_cr <= i_cfg_allow_cr;
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_held   <= n_held;
                r_halted <= n_halted;
            end
        end
    end

endmodule

FILE: rtl/upd_queue.sv
// Short queue of result bundles between the front end and the back end.
// Depends on upd_pkg.
module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  upd_pkg::t_bundle i_wr_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output upd_pkg::t_bundle o_rd_bundle
);
    import upd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full      = (r_count == CNT_FULL);
    assign o_empty     = (r_count == '0);
    assign o_rd_bundle = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/upd_back.sv
// Back end of the URL percent decoder: walks through the head bundle and
// presents one result per cycle on the output channel while it is ready.
// Depends on upd_pkg.
module upd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  upd_pkg::t_bundle i_head,
    input  logic             i_ready,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    output logic             o_string_end
);
    import upd_pkg::*;

    logic [1:0] r_idx;
    logic       take;

    assign o_valid       = !i_empty;
    assign o_out_byte    = i_head.data[r_idx];
    assign o_last_of_run = (r_idx == i_head.last_idx);
    assign o_string_end  = o_last_of_run && i_head.term;
    assign take          = o_valid && i_ready;
    assign o_pop         = take && o_last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= o_last_of_run ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

FILE: rtl/url_percent_decoder_top.sv
// Top level of the URL percent decoder: front end, bundle queue, back end.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Decodes a zero-terminated URL string arriving one byte per request and
// emits decoded bytes, one per result request. A byte that gives at most one
// result is taken every cycle while the queue is not full; a byte that gives
// several results holds the single-result output port until all of them are
// taken. The queue of DEPTH bundles lets the input side keep taking bytes
// while results wait. The first result of a byte appears only after its
// bundle has been registered in the queue. A byte that gives no result
// (start of an escape, text after a stopping question mark) is absorbed
// without a queue entry.
module url_percent_decoder_top #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_allow_cr,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_string_end
);
    import upd_pkg::*;

    t_bundle wr_bundle, head;
    logic    push, pop, full, empty;

    upd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_allow_cr(i_cfg_allow_cr),
        .i_valid       (i_valid),
        .i_char_byte   (i_char_byte),
        .i_queue_full  (full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_bundle      (wr_bundle)
    );

    upd_queue #(
        .DEPTH(DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_wr_bundle(wr_bundle),
        .i_pop      (pop),
        .o_full     (full),
        .o_empty    (empty),
        .o_rd_bundle(head)
    );

    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .i_ready      (i_ready),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_string_end (o_string_end)
    );

endmodule

FILE: rtl/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to its top level.
// Depends on url_percent_decoder_top.
module upd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run,
    input logic       o_string_end
);

    a_terminator_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_end |-> o_last_of_run && o_out_byte == 8'h00)
        else $error("Terminator result is not a final zero byte.");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid)
        else $error("A run of results was broken off before its last result.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("Result shown right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) &&
            $stable(o_last_of_run) && $stable(o_string_end))
        else $error("Stalled result changed.");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_byte   (o_out_byte),
    .o_last_of_run(o_last_of_run),
    .o_string_end (o_string_end)
);
